[sv/jeo_pkg.sv]
// shared constants and sequencer state type for the josephus elimination order block
// no dependencies
package jeo_pkg;

  localparam int MAX_PEOPLE = 64;
  localparam int PEOPLE_W   = 7;
  localparam int START_W    = 16;
  localparam int STEP_W     = 16;
  localparam int POS_W      = $clog2(MAX_PEOPLE);
  localparam int DCNT_W     = $clog2(STEP_W + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD_START,
    S_MOD_STEP,
    S_WALK,
    S_ADVANCE
  } jeo_state_t;

endpackage

[sv/josephus_elimination_order.sv]
// josephus elimination order: one start word in, one word out per eliminated person
// depends on jeo_pkg (constants, state type)
// sequence: the start is reduced modulo the people count, then per elimination the
//   remainder of the count is taken, the ring is walked over the living positions and,
//   after the elimination, skipped ahead to the next living person
// throughput: one run at a time, set by the bit-serial remainder unit and the ring walk
// reset: synchronous active low, returns to idle with an empty ring and no word pending
module josephus_elimination_order
  import jeo_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [PEOPLE_W-1:0] in_people_count,
  input  logic [START_W-1:0]  in_start_person,
  input  logic [STEP_W-1:0]   in_step_count,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [PEOPLE_W-1:0] out_eliminated_person,
  output logic                out_last_of_run
);

  jeo_state_t            state_r, state_nxt;
  logic [MAX_PEOPLE-1:0] alive_r, alive_nxt;
  logic [POS_W-1:0]      cur_r, cur_nxt;
  logic [PEOPLE_W-1:0]   remaining_r, remaining_nxt;
  logic [PEOPLE_W-1:0]   n_r, n_nxt;
  logic [STEP_W-1:0]     step_m1_r, step_m1_nxt;
  logic [STEP_W-1:0]     dvd_r, dvd_nxt;
  logic [PEOPLE_W-1:0]   rem_r, rem_nxt;
  logic [DCNT_W-1:0]     dcnt_r, dcnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [PEOPLE_W-1:0]   out_person_r, out_person_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [PEOPLE_W-1:0]   n_sat;
  logic [PEOPLE_W-1:0]   divisor;
  logic [PEOPLE_W:0]     trial;
  logic [PEOPLE_W:0]     trial_sub;
  logic [PEOPLE_W-1:0]   rem_step;
  logic [POS_W-1:0]      pos_next;
  logic                  out_free;
  logic [PEOPLE_W-1:0]   remaining_dec;

  // shared restoring remainder unit, one dividend bit per cycle
  assign divisor   = (state_r == S_MOD_START) ? n_r : remaining_r;
  assign trial     = {rem_r, dvd_r[STEP_W-1]};
  assign trial_sub = trial - {1'b0, divisor};
  assign rem_step  = (trial >= {1'b0, divisor}) ? trial_sub[PEOPLE_W-1:0]
                                                : trial[PEOPLE_W-1:0];

  assign n_sat = (in_people_count > PEOPLE_W'(MAX_PEOPLE)) ? PEOPLE_W'(MAX_PEOPLE)
                                                           : in_people_count;
  assign pos_next = ({1'b0, cur_r} == (n_r - PEOPLE_W'(1))) ? '0 : cur_r + POS_W'(1);
  assign out_free = !out_valid_r || !out_stall;
  assign remaining_dec = remaining_r - PEOPLE_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      alive_r      <= '0;
      cur_r        <= '0;
      remaining_r  <= '0;
      n_r          <= '0;
      step_m1_r    <= '0;
      dvd_r        <= '0;
      rem_r        <= '0;
      dcnt_r       <= '0;
      out_valid_r  <= 1'b0;
      out_person_r <= '0;
      out_last_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      alive_r      <= alive_nxt;
      cur_r        <= cur_nxt;
      remaining_r  <= remaining_nxt;
      n_r          <= n_nxt;
      step_m1_r    <= step_m1_nxt;
      dvd_r        <= dvd_nxt;
      rem_r        <= rem_nxt;
      dcnt_r       <= dcnt_nxt;
      out_valid_r  <= out_valid_nxt;
      out_person_r <= out_person_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    alive_nxt      = alive_r;
    cur_nxt        = cur_r;
    remaining_nxt  = remaining_r;
    n_nxt          = n_r;
    step_m1_nxt    = step_m1_r;
    dvd_nxt        = dvd_r;
    rem_nxt        = rem_r;
    dcnt_nxt       = dcnt_r;
    out_valid_nxt  = out_valid_r;
    out_person_nxt = out_person_r;
    out_last_nxt   = out_last_r;
    in_stall       = (state_r != S_IDLE);

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_people_count == '0) begin
            alive_nxt     = '0;
            cur_nxt       = '0;
            remaining_nxt = '0;
          end else begin
            n_nxt         = n_sat;
            remaining_nxt = n_sat;
            for (int i = 0; i < MAX_PEOPLE; i++) begin
              alive_nxt[i] = (PEOPLE_W'(i) < n_sat);
            end
            step_m1_nxt = (in_step_count == '0) ? '0 : in_step_count - STEP_W'(1);
            dvd_nxt     = in_start_person;
            rem_nxt     = '0;
            dcnt_nxt    = DCNT_W'(START_W);
            state_nxt   = S_MOD_START;
          end
        end
      end
      S_MOD_START: begin
        if (dcnt_r != '0) begin
          rem_nxt  = rem_step;
          dvd_nxt  = {dvd_r[STEP_W-2:0], 1'b0};
          dcnt_nxt = dcnt_r - DCNT_W'(1);
        end else begin
          cur_nxt   = (rem_r == '0) ? POS_W'(n_r - PEOPLE_W'(1))
                                    : POS_W'(rem_r - PEOPLE_W'(1));
          dvd_nxt   = step_m1_r;
          rem_nxt   = '0;
          dcnt_nxt  = DCNT_W'(STEP_W);
          state_nxt = S_MOD_STEP;
        end
      end
      S_MOD_STEP: begin
        if (dcnt_r != '0) begin
          rem_nxt  = rem_step;
          dvd_nxt  = {dvd_r[STEP_W-2:0], 1'b0};
          dcnt_nxt = dcnt_r - DCNT_W'(1);
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (rem_r != '0) begin
          cur_nxt = pos_next;
          if (alive_r[pos_next]) begin
            rem_nxt = rem_r - PEOPLE_W'(1);
          end
        end else if (out_free) begin
          alive_nxt[cur_r] = 1'b0;
          remaining_nxt    = remaining_dec;
          out_valid_nxt    = 1'b1;
          out_person_nxt   = PEOPLE_W'(cur_r) + PEOPLE_W'(1);
          out_last_nxt     = (remaining_dec == '0);
          state_nxt        = (remaining_dec == '0) ? S_IDLE : S_ADVANCE;
        end
      end
      S_ADVANCE: begin
        cur_nxt = pos_next;
        if (alive_r[pos_next]) begin
          dvd_nxt   = step_m1_r;
          rem_nxt   = '0;
          dcnt_nxt  = DCNT_W'(STEP_W);
          state_nxt = S_MOD_STEP;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid             = out_valid_r;
  assign out_eliminated_person = out_person_r;
  assign out_last_of_run       = out_last_r;

  a_walk_on_living: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && rem_r == '0) |-> alive_r[cur_r])
    else $error("count position is not a living person");

  a_remaining_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (remaining_r != '0 && remaining_r <= n_r))
    else $error("remaining count out of range during a run");

  a_alive_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD_STEP) |-> ($countones(alive_r) == int'(remaining_r)))
    else $error("alive mask disagrees with remaining count");

  a_emit_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && rem_r == '0 && out_free)
      |=> (out_valid_r && (state_r == S_IDLE || state_r == S_ADVANCE)))
    else $error("elimination did not produce a word");

endmodule
